>>> src/array_sequence_engine_assert.svh
// ----------------------------------------------------------------------------
// array sequence engine assertion macros
// shared concurrent assertion forms, sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ARRAY_SEQUENCE_ENGINE_ASSERT_SVH
`define ARRAY_SEQUENCE_ENGINE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ASE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ase_pkg.sv
// ----------------------------------------------------------------------------
// ase_pkg
// shared constants, command and status codes, and interface structs
// ----------------------------------------------------------------------------
package ase_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed port widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT     = 3'd0,
    CMD_INSERT_SORTED = 3'd1,
    CMD_ERASE_AT      = 3'd2,
    CMD_REMOVE_ALL    = 3'd3,
    CMD_READ_AT       = 3'd4,
    CMD_WRITE_AT      = 3'd5,
    CMD_FIND          = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic                   re;
    logic [IDX_W-1:0]       raddr;
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [VALUE_WIDTH-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       index;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]       removed;
    logic [CNT_W-1:0]       count;
  } res_t;

endpackage

>>> src/array_sequence_engine.sv
// ----------------------------------------------------------------------------
// array_sequence_engine
// ordered list of values held in one entry ram, with insert, sorted insert,
// erase, remove-all, read, write and find commands
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   in_       into block  in_valid / in_stall   in_cmd, in_position, in_data_value
//   out_      from block  out_valid / out_stall status, index, value, counts, empty
//
// one command at a time; read_at and write_at touch a single entry, while find,
// remove_all, erase_at and insert_at walk the list one entry per cycle, and
// insert_sorted walks to its slot, then shifts the tail one entry per cycle
// the entry ram's single read and single write port set that pace
// reset clears only the fill count and control; no clearing pass is run
// a stalled result sits in the output register while the next command runs
// ----------------------------------------------------------------------------
module array_sequence_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ase_pkg::CMD_W-1:0]        in_cmd,
  input  logic [ase_pkg::POS_W-1:0]        in_position,
  input  logic [ase_pkg::DATA_W-1:0]       in_data_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ase_pkg::STATUS_W-1:0]     out_status,
  output logic [ase_pkg::POS_W-1:0]        out_result_index,
  output logic [ase_pkg::DATA_W-1:0]       out_read_value,
  output logic [ase_pkg::COUNT_W-1:0]      out_removed_count,
  output logic [ase_pkg::COUNT_W-1:0]      out_entry_count,
  output logic                             out_is_empty
);

  ase_pkg::mem_req_t              mem_req;
  logic [ase_pkg::VALUE_WIDTH-1:0] mem_rdata;
  ase_pkg::res_t                  seq_res;
  logic                           seq_res_valid;
  logic                           seq_res_ready;

  // output stage
  logic                           out_valid_r, out_valid_nxt;
  ase_pkg::res_t                  out_res_r;
  logic                           out_empty_r;
  logic                           load;

  // entry store, one word per list slot
  ase_ram #(
    .WIDTH (ase_pkg::VALUE_WIDTH),
    .DEPTH (ase_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata)
  );

  // sequencer walks the ram for each command
  ase_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_position   (in_position),
    .in_data_value (in_data_value),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res_valid     (seq_res_valid),
    .res_ready     (seq_res_ready),
    .res           (seq_res)
  );

  // slot is free when empty or when the held result transfers this cycle
  assign seq_res_ready = !out_valid_r || !out_stall;
  assign load          = seq_res_valid && seq_res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, held steady while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r   <= seq_res;
      out_empty_r <= (seq_res.count == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_result_index  = ase_pkg::POS_W'(out_res_r.index);
  assign out_read_value    = ase_pkg::DATA_W'(out_res_r.value);
  assign out_removed_count = ase_pkg::COUNT_W'(out_res_r.removed);
  assign out_entry_count   = ase_pkg::COUNT_W'(out_res_r.count);
  assign out_is_empty      = out_empty_r;

endmodule

>>> src/ase_ram.sv
// ----------------------------------------------------------------------------
// ase_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/ase_seq.sv
// ----------------------------------------------------------------------------
// ase_seq
// command sequencer: scans, shifts and compacts the entry ram one entry a cycle
// ----------------------------------------------------------------------------
`include "array_sequence_engine_assert.svh"

module ase_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ase_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ase_pkg::POS_W-1:0]     in_position,
  input  logic [ase_pkg::DATA_W-1:0]    in_data_value,
  output ase_pkg::mem_req_t             mem_req,
  input  logic [ase_pkg::VALUE_WIDTH-1:0] mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ase_pkg::res_t                 res
);

  localparam int VW = ase_pkg::VALUE_WIDTH;
  localparam int IW = ase_pkg::IDX_W;
  localparam int CW = ase_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(ase_pkg::CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN     = 6'b000010,
    S_SHIFT_UP = 6'b000100,
    S_SHIFT_DN = 6'b001000,
    S_ACCESS   = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  ase_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [VW-1:0]   val_r, val_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [IW-1:0]   ridx_r, ridx_nxt;
  logic            rvld_r, rvld_nxt;
  logic [CW-1:0]   wptr_r, wptr_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  ase_pkg::res_t   res_r, res_nxt;

  logic [CW-1:0]   in_pos_ext;
  logic            hit_eq, hit_ge, scan_hit;

  assign in_pos_ext = CW'(in_position);
  assign hit_eq     = (mem_rdata == val_r);
  assign hit_ge     = !(mem_rdata < val_r);
  assign scan_hit   = rvld_r && (((cmd_r == ase_pkg::CMD_FIND) && hit_eq) ||
                                 ((cmd_r == ase_pkg::CMD_INSERT_SORTED) && hit_ge));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    ptr_nxt   = ptr_r;
    ridx_nxt  = ridx_r;
    rvld_nxt  = rvld_r;
    wptr_nxt  = wptr_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    mem_req   = '0;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = ase_pkg::cmd_t'(in_cmd);
          pos_nxt  = IW'(in_position);
          val_nxt  = VW'(in_data_value);
          ptr_nxt  = '0;
          wptr_nxt = '0;
          rem_nxt  = '0;
          rvld_nxt = 1'b0;
          res_nxt  = '{status: ase_pkg::ST_REJECT, index: '0, value: '0,
                       removed: '0, count: cnt_r};
          state_nxt = S_FINISH;
          unique case (ase_pkg::cmd_t'(in_cmd))
            ase_pkg::CMD_INSERT_AT: begin
              if (cnt_r < CAP_CNT && in_pos_ext <= cnt_r) begin
                ptr_nxt   = cnt_r;
                state_nxt = S_SHIFT_UP;
              end
            end
            ase_pkg::CMD_INSERT_SORTED: begin
              if (cnt_r < CAP_CNT) begin
                state_nxt = S_SCAN;
              end
            end
            ase_pkg::CMD_ERASE_AT: begin
              if (in_pos_ext < cnt_r) begin
                ptr_nxt   = in_pos_ext + CW'(1);
                state_nxt = S_SHIFT_DN;
              end
            end
            ase_pkg::CMD_REMOVE_ALL,
            ase_pkg::CMD_FIND: begin
              state_nxt = S_SCAN;
            end
            ase_pkg::CMD_READ_AT,
            ase_pkg::CMD_WRITE_AT: begin
              if (in_pos_ext < cnt_r) begin
                state_nxt = S_ACCESS;
              end
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        // compaction for remove_all: keep entries that differ from the value
        if (cmd_r == ase_pkg::CMD_REMOVE_ALL && rvld_r) begin
          if (!hit_eq) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wptr_r[IW-1:0];
            mem_req.wdata = mem_rdata;
            wptr_nxt      = wptr_r + CW'(1);
          end else begin
            rem_nxt = rem_r + CW'(1);
          end
        end
        if (scan_hit) begin
          rvld_nxt = 1'b0;
          if (cmd_r == ase_pkg::CMD_FIND) begin
            res_nxt   = '{status: ase_pkg::ST_OK, index: ridx_r, value: '0,
                          removed: '0, count: cnt_r};
            state_nxt = S_FINISH;
          end else begin
            pos_nxt   = ridx_r;
            ptr_nxt   = cnt_r;
            state_nxt = S_SHIFT_UP;
          end
        end else if (ptr_r >= cnt_r) begin
          rvld_nxt = 1'b0;
          priority case (cmd_r)
            ase_pkg::CMD_FIND: begin
              res_nxt   = '{status: ase_pkg::ST_NOT_FOUND, index: '0, value: '0,
                            removed: '0, count: cnt_r};
              state_nxt = S_FINISH;
            end
            ase_pkg::CMD_INSERT_SORTED: begin
              pos_nxt   = cnt_r[IW-1:0];
              ptr_nxt   = cnt_r;
              state_nxt = S_SHIFT_UP;
            end
            default: begin
              cnt_nxt   = wptr_nxt;
              res_nxt   = '{status: ase_pkg::ST_OK, index: '0, value: '0,
                            removed: rem_nxt, count: wptr_nxt};
              state_nxt = S_FINISH;
            end
          endcase
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r[IW-1:0];
          ridx_nxt      = ptr_r[IW-1:0];
          ptr_nxt       = ptr_r + CW'(1);
          rvld_nxt      = 1'b1;
        end
      end

      S_SHIFT_UP: begin
        if (rvld_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ridx_r + IW'(1);
          mem_req.wdata = mem_rdata;
        end else if (ptr_r == CW'(pos_r)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = val_r;
          cnt_nxt       = cnt_r + CW'(1);
          res_nxt       = '{status: ase_pkg::ST_OK, index: pos_r, value: '0,
                            removed: '0, count: cnt_r + CW'(1)};
          state_nxt     = S_FINISH;
        end
        if (ptr_r > CW'(pos_r)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IW'(ptr_r - CW'(1));
          ridx_nxt      = IW'(ptr_r - CW'(1));
          ptr_nxt       = ptr_r - CW'(1);
          rvld_nxt      = 1'b1;
        end else begin
          rvld_nxt = 1'b0;
        end
      end

      S_SHIFT_DN: begin
        if (rvld_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ridx_r - IW'(1);
          mem_req.wdata = mem_rdata;
        end
        if (ptr_r < cnt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r[IW-1:0];
          ridx_nxt      = ptr_r[IW-1:0];
          ptr_nxt       = ptr_r + CW'(1);
          rvld_nxt      = 1'b1;
        end else begin
          rvld_nxt  = 1'b0;
          cnt_nxt   = cnt_r - CW'(1);
          res_nxt   = '{status: ase_pkg::ST_OK, index: '0, value: '0,
                        removed: '0, count: cnt_r - CW'(1)};
          state_nxt = S_FINISH;
        end
      end

      S_ACCESS: begin
        if (cmd_r == ase_pkg::CMD_WRITE_AT) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = val_r;
          res_nxt       = '{status: ase_pkg::ST_OK, index: '0, value: '0,
                            removed: '0, count: cnt_r};
          state_nxt     = S_FINISH;
        end else if (!rvld_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = pos_r;
          rvld_nxt      = 1'b1;
        end else begin
          rvld_nxt  = 1'b0;
          res_nxt   = '{status: ase_pkg::ST_OK, index: '0, value: mem_rdata,
                        removed: '0, count: cnt_r};
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        rvld_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    ptr_r  <= ptr_nxt;
    ridx_r <= ridx_nxt;
    wptr_r <= wptr_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign res      = res_r;

  `ASE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != S_IDLE, "accepted command left sequencer idle")
  `ASE_ASSERT_SAME(a_no_same_entry, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit the same entry")
  `ASE_ASSERT_NEXT(a_idle_count_holds, state_r == S_IDLE, $stable(cnt_r), "entry count moved while idle")
  `ASE_ASSERT_SAME(a_read_in_work_state, rvld_r, state_r == S_SCAN || state_r == S_SHIFT_UP || state_r == S_SHIFT_DN || state_r == S_ACCESS, "read pending outside a work state")

endmodule
